/* rtl/stereo_sample_fifo_drop_oldest_assert.svh */
// Assertion macros used by the checker file.
// Each use names a label, an antecedent, a consequent and a message.
`ifndef STEREO_SAMPLE_FIFO_DROP_OLDEST_ASSERT_SVH
`define STEREO_SAMPLE_FIFO_DROP_OLDEST_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SSFDO_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SSFDO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/ssfdo_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ssfdo_pkg;

	// Sizing
	localparam int PAIR_DEPTH     = 1024;
	localparam int MAX_READ_PAIRS = 32;
	localparam int PTR_W          = $clog2(PAIR_DEPTH);
	localparam int CNT_W          = $clog2(PAIR_DEPTH + 1);
	localparam int PAIR_W         = 32;
	localparam int SAMPLE_W       = 16;
	localparam int WANT_W         = 6;
	localparam int HELD_W         = 11;
	localparam int MAXR_W         = $clog2(MAX_READ_PAIRS + 1);
	localparam int CMP_A          = (CNT_W > WANT_W) ? CNT_W : WANT_W;
	localparam int CMP_W          = (CMP_A > MAXR_W) ? CMP_A : MAXR_W;

	// Request function codes
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_READ  = 1'b1;

	// Result status codes
	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_DROP   = 2'd1;
	localparam logic [1:0] STATUS_NODATA = 2'd2;

	typedef struct packed {
		logic                       func;
		logic signed [SAMPLE_W-1:0] left_in;
		logic signed [SAMPLE_W-1:0] right_in;
		logic                       end_of_block;
		logic [WANT_W-1:0]          pairs_wanted;
	} req_t;

	typedef struct packed {
		logic signed [PAIR_W-1:0] left_out;
		logic signed [PAIR_W-1:0] right_out;
		logic                     last;
		logic [1:0]               status;
		logic [HELD_W-1:0]        pairs_held;
	} rsp_t;

	// Ring pointer advance with wrap at the depth
	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(PAIR_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

endpackage

`default_nettype wire

/* rtl/stereo_sample_fifo_drop_oldest.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                     Direction  Transfer when
// request   req_valid, req_stall, req   in         req_valid && !req_stall
// result    rsp_valid, rsp_stall, rsp   out        rsp_valid && !rsp_stall
//
// Writes can follow back to back while the output queue has room.
// A read of N pairs: one memory read port, one pair a cycle while there is room.
// Results pass a registered memory read stage, then a two-entry output queue.
// Reset clears pointers, count and control; the pair memory has no clearing pass.
// Result stalls fill the queue, which then stalls requests and memory reads.
module stereo_sample_fifo_drop_oldest (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  ssfdo_pkg::req_t   req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output ssfdo_pkg::rsp_t   rsp
);
	import ssfdo_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_READ = 2'b10
	} state_t;

	state_t            state_q;
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  held_q;
	logic [WANT_W-1:0] rem_q;

	logic [PAIR_W-1:0] mem [PAIR_DEPTH];

	logic              valid_s1;
	logic              from_mem_s1;
	logic              last_s1;
	logic [1:0]        status_s1;
	logic [PAIR_W-1:0] data_s1;
	logic [PAIR_W-1:0] rdata_s1;

	rsp_t              q_q [2];
	logic              head_q;
	logic [1:0]        count_q;

	logic              pop;
	logic [1:0]        occ;
	logic              space;
	logic              accept;
	logic              is_write;
	logic              full;
	logic [WANT_W-1:0] want;
	logic              want_ok;
	logic              issue;
	logic              tail;
	logic [PAIR_W-1:0] word;
	rsp_t              entry;

	// Flow control: room counts the queue plus the result in flight
	assign pop      = rsp_valid && !rsp_stall;
	assign occ      = count_q + {1'b0, valid_s1};
	assign space    = (occ < 2'd2) || ((occ == 2'd2) && pop);
	assign req_stall = (state_q != ST_IDLE) || !space;
	assign accept   = req_valid && !req_stall;
	assign is_write = (req.func == FUNC_WRITE);
	assign full     = (held_q == CNT_W'(PAIR_DEPTH));
	assign want     = req.pairs_wanted;
	assign want_ok  = (want != '0)
		&& (CMP_W'(want) <= CMP_W'(MAX_READ_PAIRS))
		&& (CMP_W'(want) <= CMP_W'(held_q));
	assign issue    = (state_q == ST_READ) && space;

	// Pair memory: one write and one registered read a cycle. Writes are only
	// taken while idle, so a read never meets a write to the same entry.
	always_ff @(posedge clk) begin
		if (accept && is_write) begin
			mem[wr_ptr_q] <= {req.left_in, req.right_in};
		end
		if (issue) begin
			rdata_s1 <= mem[rd_ptr_q];
		end
	end

	// Pointers, fill count and read sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			held_q   <= '0;
			rem_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (accept && !(!is_write && want_ok)) || issue;
			if (accept && is_write) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
				if (full) begin
					rd_ptr_q <= next_ptr(rd_ptr_q);
				end else begin
					held_q <= held_q + CNT_W'(1);
				end
			end
			if (accept && !is_write && want_ok) begin
				held_q  <= held_q - CNT_W'(want);
				rem_q   <= want;
				state_q <= ST_READ;
			end
			if (issue) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
				rem_q    <= rem_q - WANT_W'(1);
				if (rem_q == WANT_W'(1)) begin
					state_q <= ST_IDLE;
				end
			end
		end
	end

	// Result stage payload
	always_ff @(posedge clk) begin
		from_mem_s1 <= issue;
		last_s1     <= issue ? (rem_q == WANT_W'(1)) : 1'b1;
		data_s1     <= '0;
		status_s1   <= STATUS_OK;
		if (accept && is_write) begin
			data_s1   <= {req.left_in, req.right_in};
			status_s1 <= full ? STATUS_DROP : STATUS_OK;
		end else if (accept && want != '0 && !want_ok) begin
			status_s1 <= STATUS_NODATA;
		end
	end

	// Widen the pair: each sample into the high half of a 32-bit word
	assign word = from_mem_s1 ? rdata_s1 : data_s1;
	always_comb begin
		entry.left_out   = {word[PAIR_W-1:SAMPLE_W], {SAMPLE_W{1'b0}}};
		entry.right_out  = {word[SAMPLE_W-1:0], {SAMPLE_W{1'b0}}};
		entry.last       = last_s1;
		entry.status     = status_s1;
		entry.pairs_held = HELD_W'(held_q);
	end

	// Output queue, two entries
	assign tail = head_q ^ count_q[0];

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			q_q[tail] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= 1'b0;
			count_q <= '0;
		end else begin
			head_q  <= head_q ^ pop;
			count_q <= count_q + {1'b0, valid_s1} - {1'b0, pop};
		end
	end

	assign rsp_valid = (count_q != '0);
	assign rsp       = q_q[head_q];

endmodule

`default_nettype wire

/* rtl/ssfdo_chk.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "stereo_sample_fifo_drop_oldest_assert.svh"

module ssfdo_chk (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_stall,
	input ssfdo_pkg::req_t req,
	input logic            rsp_valid,
	input logic            rsp_stall,
	input ssfdo_pkg::rsp_t rsp
);
	import ssfdo_pkg::*;

	// Stalled result holds until its transfer
	`SSFDO_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "result changed under stall")

	// A failed read carries no samples and closes its item
	`SSFDO_ASSERT_SAME(a_nodata_empty, rsp_valid && rsp.status == STATUS_NODATA, rsp.last && rsp.left_out == 0 && rsp.right_out == 0, "failed read result malformed")

	// A drop only happens on a full ring, and a write gives one result
	`SSFDO_ASSERT_SAME(a_drop_full, rsp_valid && rsp.status == STATUS_DROP, rsp.last && rsp.pairs_held == HELD_W'(PAIR_DEPTH), "drop reported on a ring that is not full")

	// Widened samples keep their low halves clear
	`SSFDO_ASSERT_SAME(a_low_zero, rsp_valid, rsp.left_out[15:0] == 16'd0 && rsp.right_out[15:0] == 16'd0, "low half of a sample not zero")

endmodule

bind stereo_sample_fifo_drop_oldest ssfdo_chk u_chk (.*);

`default_nettype wire
